// File: rtl/rcpp_pkg.sv
// Package: constants, types and the command decode shared by the parser modules.
`default_nettype none

package rcpp_pkg;

  localparam int unsigned MaxFrame  = 64;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned PosW      = 7;
  localparam int unsigned GainW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned OutDataW  = 48;

  localparam logic [ByteW-1:0] CmdSpeedLow  = 8'h59;
  localparam logic [ByteW-1:0] CmdSpeedHigh = 8'h58;
  localparam logic [ByteW-1:0] CmdDirFirst  = 8'h41;
  localparam logic [ByteW-1:0] CmdDirLast   = 8'h48;
  localparam logic [ByteW-1:0] FrameOpen    = 8'h7B;
  localparam logic [ByteW-1:0] FrameClose   = 8'h7D;
  localparam logic [ByteW-1:0] ReportMark   = 8'h50;
  localparam logic [ByteW-1:0] IdGainFirst  = 8'h30;
  localparam logic [ByteW-1:0] IdGainLast   = 8'h33;
  localparam logic [ByteW-1:0] DigitZero    = 8'h30;

  localparam logic [PosW-1:0] PosParamId = 7'd1;
  localparam logic [PosW-1:0] PosThird   = 7'd3;

  typedef struct packed {
    logic fwd;
    logic bwd;
    logic left;
    logic right;
  } dir_t;

  typedef struct packed {
    logic                    report_request;
    logic signed [GainW-1:0] gain_value;
    logic [1:0]              gain_select;
    logic                    gain_write;
    logic                    speed_high;
    logic                    turn_right;
    logic                    turn_left;
    logic                    go_backward;
    logic                    go_forward;
  } result_t;

  function automatic dir_t dir_decode(input logic [ByteW-1:0] b);
    dir_t d;
    d = '0;
    unique case (b)
      8'h41:   d = 4'b1000;
      8'h42:   d = 4'b1001;
      8'h43:   d = 4'b0001;
      8'h44:   d = 4'b0110;
      8'h45:   d = 4'b0100;
      8'h46:   d = 4'b0101;
      8'h47:   d = 4'b0010;
      8'h48:   d = 4'b1010;
      default: d = 4'b0000;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rcpp_fold.sv
// Saturating decimal fold: acc * 10 + (byte - '0'), clamped to the accumulator range.
`default_nettype none

module rcpp_fold
  import rcpp_pkg::*;
(
  input  wire logic signed [ValueBits-1:0] acc_i,
  input  wire logic        [ByteW-1:0]     byte_i,
  output      logic signed [ValueBits-1:0] acc_o
);

  localparam int unsigned ExtW = ValueBits + 5;
  localparam logic signed [ExtW-1:0] ExtMax =
    ExtW'({1'b0, {(ValueBits-1){1'b1}}});
  localparam logic signed [ExtW-1:0] ExtMin = -ExtMax - ExtW'(1);

  logic signed [ExtW-1:0] acc_ext;
  logic signed [ExtW-1:0] digit;
  logic signed [ExtW-1:0] sum;

  always_comb begin
    acc_ext = ExtW'(acc_i);
    digit   = ExtW'({1'b0, byte_i}) - ExtW'({1'b0, DigitZero});
    sum     = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;
    if (sum > ExtMax) begin
      acc_o = ExtMax[ValueBits-1:0];
    end else if (sum < ExtMin) begin
      acc_o = ExtMin[ValueBits-1:0];
    end else begin
      acc_o = sum[ValueBits-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/remote_command_and_param_parser.sv
// Top level: remote-control byte decoder with parameter frame parser.
//
//  channel  | dir | tdata fields (low bit up)
//  ---------+-----+--------------------------------------------------------------
//  s_axis   | in  | rx_byte[7:0]
//  m_axis   | out | go_forward, go_backward, turn_left, turn_right, speed_high,
//           |     | gain_write, gain_select[1:0], gain_value[31:0], report_request
//
// One beat in, one beat out; a new byte is taken every cycle while the output is not stalled.
// The path is an input register, then the decode feeding the result register; the decimal
// fold (one multiply-by-ten add with saturation) updates the parameter accumulator.
// Reset clears the frame state and selects low speed.
// A stalled result register holds the input register; one more byte is held there.
`default_nettype none

module remote_command_and_param_parser
  import rcpp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // rx_byte[7:0]
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata    // see table above, zero padded
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q, out_d;

  logic in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] param_id_q, param_id_d;
  logic [ByteW-1:0] third_q, third_d;
  logic signed [ValueBits-1:0] acc_q, acc_d, acc_fold;
  logic speed_q, speed_d;

  logic advance;
  logic in_take;
  logic open_now;
  dir_t dir;
  logic signed [63:0] acc_wide;
  logic signed [GainW-1:0] gain_sat;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  rcpp_fold u_fold (
    .acc_i  (acc_q),
    .byte_i (in_byte_q),
    .acc_o  (acc_fold)
  );

  always_comb begin
    acc_wide = 64'(acc_q);
    if (acc_wide > 64'sd2147483647) begin
      gain_sat = GainW'(32'h7FFF_FFFF);
    end else if (acc_wide < -64'sd2147483648) begin
      gain_sat = GainW'(32'h8000_0000);
    end else begin
      gain_sat = acc_wide[GainW-1:0];
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    param_id_d = param_id_q;
    third_d    = third_q;
    acc_d      = acc_q;
    speed_d    = speed_q;
    dir        = dir_decode(in_byte_q);
    open_now   = in_frame_q || (in_byte_q == FrameOpen);
    out_d      = '0;

    if (in_byte_q == CmdSpeedLow) speed_d = 1'b0;
    if (in_byte_q == CmdSpeedHigh) speed_d = 1'b1;
    if (in_byte_q == FrameOpen) in_frame_d = 1'b1;

    if (in_byte_q == FrameClose) begin
      if (third_q == ReportMark) begin
        out_d.report_request = 1'b1;
      end else if (param_id_q >= IdGainFirst && param_id_q <= IdGainLast) begin
        out_d.gain_write  = 1'b1;
        out_d.gain_select = param_id_q[1:0];
        out_d.gain_value  = gain_sat;
      end
      in_frame_d = 1'b0;
      pos_d      = '0;
      param_id_d = '0;
      third_d    = '0;
      acc_d      = '0;
    end else if (open_now && pos_q < PosW'(MaxFrame)) begin
      if (pos_q == PosParamId) param_id_d = in_byte_q;
      if (pos_q == PosThird) third_d = in_byte_q;
      if (pos_q >= PosThird) acc_d = acc_fold;
      pos_d = pos_q + PosW'(1);
    end

    out_d.go_forward  = dir.fwd;
    out_d.go_backward = dir.bwd;
    out_d.turn_left   = dir.left;
    out_d.turn_right  = dir.right;
    out_d.speed_high  = speed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      param_id_q  <= '0;
      third_q     <= '0;
      acc_q       <= '0;
      speed_q     <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
      if (advance && in_valid_q) begin
        in_frame_q <= in_frame_d;
        pos_q      <= pos_d;
        param_id_q <= param_id_d;
        third_q    <= third_d;
        acc_q      <= acc_d;
        speed_q    <= speed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= s_axis_tdata;
    if (advance && in_valid_q) out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

endmodule

`default_nettype wire
